// File: sv/rdfq_pkg.sv
// Package for the RED drop FIFO queue: sizes, status codes, register
// indexes, the controller state type and the configuration struct.
// No dependencies; every file but rdfq_ram imports it.
package rdfq_pkg;

   // Storage and field sizes.
   localparam int FIFO_DEPTH  = 64;
   localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);
   localparam int TAG_BITS    = 16;
   localparam int RANDOM_BITS = 16;
   localparam int CFG_BITS    = 7;
   localparam int TOTAL_BITS  = 32;
   localparam int STATUS_BITS = 3;
   localparam int PROD_BITS   = RANDOM_BITS + CFG_BITS;

   // Configuration port sizes.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_QUEUE_LIMIT    = 2'd0;
   localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd1;
   localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd2;

   // Register reset values.
   localparam logic [CFG_BITS-1:0] RST_QUEUE_LIMIT    = CFG_BITS'(64);
   localparam logic [CFG_BITS-1:0] RST_LOW_THRESHOLD  = CFG_BITS'(16);
   localparam logic [CFG_BITS-1:0] RST_HIGH_THRESHOLD = CFG_BITS'(48);

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_SERVED    = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_TAIL      = 3'd2,
      ST_EARLY     = 3'd3,
      ST_FWD_IDLE  = 3'd4,
      ST_FWD_NEXT  = 3'd5,
      ST_IDLE_DONE = 3'd6
   } status_type;

   // Operation codes of an input word.
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_DONE    = 1'b1;

   // Controller states.
   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Configuration registers as seen by the core.
   typedef struct packed {
      logic [CFG_BITS-1:0] queue_limit;
      logic [CFG_BITS-1:0] low_threshold;
      logic [CFG_BITS-1:0] high_threshold;
   } cfg_type;

endpackage

// File: sv/rdfq_req_if.sv
// Request channel interface: valid/ready handshake with the packet event word.
// Depends on rdfq_pkg.
interface rdfq_req_if;
   import rdfq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [TAG_BITS-1:0]    packet_tag;
   logic [RANDOM_BITS-1:0] random_value;

   modport source (output valid, output operation, output packet_tag,
                   output random_value, input ready);
   modport sink   (input valid, input operation, input packet_tag,
                   input random_value, output ready);
endinterface

// File: sv/rdfq_rsp_if.sv
// Response channel interface: valid/ready handshake with the result word.
// Depends on rdfq_pkg.
interface rdfq_rsp_if;
   import rdfq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [TAG_BITS-1:0]    forwarded_tag;
   logic [TAG_BITS-1:0]    serving_tag;
   logic                   server_busy;
   logic [CNT_BITS-1:0]    queue_length;
   logic [TOTAL_BITS-1:0]  received_count;
   logic [TOTAL_BITS-1:0]  dropped_count;
   logic [TOTAL_BITS-1:0]  forwarded_count;

   modport source (output valid, output status, output forwarded_tag,
                   output serving_tag, output server_busy, output queue_length,
                   output received_count, output dropped_count,
                   output forwarded_count, input ready);
   modport sink   (input valid, input status, input forwarded_tag,
                   input serving_tag, input server_busy, input queue_length,
                   input received_count, input dropped_count,
                   input forwarded_count, output ready);
endinterface

// File: sv/rdfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rdfq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rdfq_csr.sv
// Configuration register block on an APB-style port: queue limit and the
// two drop thresholds. Depends on rdfq_pkg.
module rdfq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rdfq_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [rdfq_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [rdfq_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output rdfq_pkg::cfg_type                    cfg
);
   import rdfq_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_strobe;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_strobe = psel && penable && pwrite;

   // Register write decode; addresses past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_index)
            REG_QUEUE_LIMIT:    cfg_in.queue_limit    = pwdata[CFG_BITS-1:0];
            REG_LOW_THRESHOLD:  cfg_in.low_threshold  = pwdata[CFG_BITS-1:0];
            REG_HIGH_THRESHOLD: cfg_in.high_threshold = pwdata[CFG_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_limit    <= RST_QUEUE_LIMIT;
         cfg_ff.low_threshold  <= RST_LOW_THRESHOLD;
         cfg_ff.high_threshold <= RST_HIGH_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_index)
         REG_QUEUE_LIMIT:    prdata = CSR_DATA_BITS'(cfg_ff.queue_limit);
         REG_LOW_THRESHOLD:  prdata = CSR_DATA_BITS'(cfg_ff.low_threshold);
         REG_HIGH_THRESHOLD: prdata = CSR_DATA_BITS'(cfg_ff.high_threshold);
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/rdfq_core.sv
// Queue controller: takes one packet event word, reads the FIFO head from the
// tag memory, makes the serve/queue/drop decision and registers the result.
// Depends on rdfq_pkg, rdfq_ram and the two channel interfaces.
module rdfq_core (
   input  logic              clock,
   input  logic              reset,
   input  rdfq_pkg::cfg_type cfg,
   rdfq_req_if.sink          req_bus,
   rdfq_rsp_if.source        rsp_bus
);
   import rdfq_pkg::*;

   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(FIFO_DEPTH - 1);
   localparam logic [CFG_BITS-1:0] DEPTH_CFG = CFG_BITS'(FIFO_DEPTH);

   state_type state_ff, state_in;

   // Captured input word.
   logic                   op_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic [RANDOM_BITS-1:0] rnd_ff;

   // Queue state.
   logic                  busy_ff, busy_in;
   logic [TAG_BITS-1:0]   cur_tag_ff, cur_tag_in;
   logic [PTR_BITS-1:0]   head_ff, head_in;
   logic [PTR_BITS-1:0]   tail_ff, tail_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [TOTAL_BITS-1:0] arr_ff, arr_in;
   logic [TOTAL_BITS-1:0] drop_ff, drop_in;
   logic [TOTAL_BITS-1:0] fwd_ff, fwd_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   status_type            out_status_ff, out_status_in;
   logic [TAG_BITS-1:0]   out_fwd_tag_ff, out_fwd_tag_in;

   // Memory port signals.
   logic                  req_take;
   logic                  mem_wr_en;
   logic [TAG_BITS-1:0]   head_tag;

   // Decision terms.
   logic                  out_free;
   logic [CFG_BITS-1:0]   eff_limit;
   logic [CFG_BITS-1:0]   fill_cfg;
   logic [CFG_BITS-1:0]   span;
   logic [PROD_BITS-1:0]  rnd_prod;
   logic [PROD_BITS-1:0]  excess_scaled;
   logic                  early_hit;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   // Tag memory; the head is read at accept time, so the entry is ready in
   // the execute cycle. Writes happen only in the execute cycle, so the two
   // ports never touch the memory in the same cycle.
   rdfq_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (FIFO_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (tail_ff),
      .wr_data (tag_ff),
      .rd_en   (req_take),
      .rd_addr (head_ff),
      .rd_data (head_tag)
   );

   // Early drop test: r * (high - low) < (n - low) << RANDOM_BITS.
   assign fill_cfg      = CFG_BITS'(fill_ff);
   assign eff_limit     = (cfg.queue_limit > DEPTH_CFG) ? DEPTH_CFG : cfg.queue_limit;
   assign span          = cfg.high_threshold - cfg.low_threshold;
   assign rnd_prod      = PROD_BITS'(rnd_ff) * PROD_BITS'(span);
   assign excess_scaled = PROD_BITS'(fill_cfg - cfg.low_threshold) << RANDOM_BITS;

   always_comb begin
      if (fill_cfg <= cfg.low_threshold) begin
         early_hit = 1'b0;
      end else if (fill_cfg >= cfg.high_threshold) begin
         early_hit = 1'b1;
      end else begin
         early_hit = rnd_prod < excess_scaled;
      end
   end

   // Next state and queue update.
   always_comb begin
      state_in       = state_ff;
      busy_in        = busy_ff;
      cur_tag_in     = cur_tag_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      arr_in         = arr_ff;
      drop_in        = drop_ff;
      fwd_in         = fwd_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_status_in  = out_status_ff;
      out_fwd_tag_in = out_fwd_tag_ff;
      mem_wr_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in       = S_IDLE;
               out_valid_in   = 1'b1;
               out_fwd_tag_in = '0;
               if (op_ff == OP_DONE) begin
                  if (!busy_ff) begin
                     out_status_in = ST_IDLE_DONE;
                  end else begin
                     out_fwd_tag_in = cur_tag_ff;
                     fwd_in = (&fwd_ff) ? fwd_ff : fwd_ff + 1'b1;
                     if (fill_ff == '0) begin
                        busy_in       = 1'b0;
                        cur_tag_in    = '0;
                        out_status_in = ST_FWD_IDLE;
                     end else begin
                        cur_tag_in    = head_tag;
                        head_in       = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
                        fill_in       = fill_ff - 1'b1;
                        out_status_in = ST_FWD_NEXT;
                     end
                  end
               end else begin
                  arr_in = (&arr_ff) ? arr_ff : arr_ff + 1'b1;
                  if (!busy_ff) begin
                     busy_in       = 1'b1;
                     cur_tag_in    = tag_ff;
                     out_status_in = ST_SERVED;
                  end else if (fill_cfg >= eff_limit) begin
                     drop_in       = (&drop_ff) ? drop_ff : drop_ff + 1'b1;
                     out_status_in = ST_TAIL;
                  end else if (early_hit) begin
                     drop_in       = (&drop_ff) ? drop_ff : drop_ff + 1'b1;
                     out_status_in = ST_EARLY;
                  end else begin
                     mem_wr_en     = 1'b1;
                     tail_in       = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                     fill_in       = fill_ff + 1'b1;
                     out_status_in = ST_QUEUED;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and queue state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         cur_tag_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         arr_ff       <= '0;
         drop_ff      <= '0;
         fwd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         cur_tag_ff   <= cur_tag_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         arr_ff       <= arr_in;
         drop_ff      <= drop_in;
         fwd_ff       <= fwd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_bus.operation;
         tag_ff <= req_bus.packet_tag;
         rnd_ff <= req_bus.random_value;
      end
      out_status_ff  <= out_status_in;
      out_fwd_tag_ff <= out_fwd_tag_in;
   end

   // The result word shows the queue state left by the last item; no item
   // executes while an older result is still held.
   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = out_status_ff;
   assign rsp_bus.forwarded_tag   = out_fwd_tag_ff;
   assign rsp_bus.serving_tag     = cur_tag_ff;
   assign rsp_bus.server_busy     = busy_ff;
   assign rsp_bus.queue_length    = fill_ff;
   assign rsp_bus.received_count  = arr_ff;
   assign rsp_bus.dropped_count   = drop_ff;
   assign rsp_bus.forwarded_count = fwd_ff;

endmodule

// File: sv/red_drop_fifo_queue.sv
// RED drop FIFO queue, top level: configuration registers and queue core.
// On accept the request word is registered and the tag memory reads the FIFO
// head; the execute state decides and registers the result word, and only then
// is a new word taken. A held result stalls the next decision, not the accept.
// Reset is synchronous and active high; it clears pointers, counts and flags.
// The tag memory is not cleared, since only filled entries are ever used.
module red_drop_fifo_queue (
   input  logic                               clock,
   input  logic                               reset,
   rdfq_req_if.sink                           req_bus,
   rdfq_rsp_if.source                         rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rdfq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [rdfq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [rdfq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import rdfq_pkg::*;

   cfg_type cfg;

   // Configuration registers.
   rdfq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Queue controller with its tag memory.
   rdfq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: sv/rdfq_checker.sv
// Port-level checker for the RED drop FIFO queue, bound to the top level.
// Depends on rdfq_pkg.
module rdfq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rdfq_pkg::STATUS_BITS-1:0]   rsp_status,
   input logic [rdfq_pkg::TAG_BITS-1:0]      rsp_forwarded_tag,
   input logic [rdfq_pkg::TAG_BITS-1:0]      rsp_serving_tag,
   input logic                               rsp_server_busy,
   input logic [rdfq_pkg::CNT_BITS-1:0]      rsp_queue_length
);
   import rdfq_pkg::*;

   // A result word stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // An idle server reports no tag in service.
   a_idle_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_server_busy |-> rsp_serving_tag == '0)
      else $error("idle server shows a serving tag");

   // A completion that empties the server leaves an empty queue.
   a_fwd_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FWD_IDLE |-> !rsp_server_busy && rsp_queue_length == '0)
      else $error("server went idle with packets waiting");

   // A completion while idle forwards nothing.
   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IDLE_DONE |-> !rsp_server_busy && rsp_forwarded_tag == '0)
      else $error("idle completion forwarded a tag");

   // Packets wait only behind a busy server.
   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_length != '0 |-> rsp_server_busy)
      else $error("packets waiting while the server is idle");

endmodule

bind red_drop_fifo_queue rdfq_checker u_rdfq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_forwarded_tag (rsp_bus.forwarded_tag),
   .rsp_serving_tag   (rsp_bus.serving_tag),
   .rsp_server_busy   (rsp_bus.server_busy),
   .rsp_queue_length  (rsp_bus.queue_length)
);
